// ----- rtl/ptts_pkg.sv -----
package ptts_pkg;

  // Fixed by the result format: at most this many fire results per tick
  localparam int MAX_RESULTS = 8;

  localparam int TASK_SLOTS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  // Width of the slot field
  localparam int SLOT_W = 8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_REG   = 2'd1,
    ACT_STATE = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_FIRE   = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_PRIO = 2'd1,
    STAT_NULL     = 2'd2,
    STAT_UNREG    = 2'd3
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [SLOT_W-1:0]   slot;
    logic                task_present;
    logic [15:0]         start_delay;
    logic [15:0]         period;
    logic                active;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  task_index;
    status_e     status;
    logic        last;
  } out_item_t;

  // Control of one cell: rotate along the row, or load from a transaction
  typedef struct packed {
    logic shift;
    logic wr_task;
    logic wr_state;
    logic active;
  } cell_ctrl_t;

endpackage

// ----- rtl/periodic_task_tick_scheduler_unit.sv -----
// Channel  Direction  Payload     Handshake
// in       input      in_item_t   in_valid_i / in_stall_o
// out      output     out_item_t  out_valid_o / out_stall_i
//
// A register or state transaction gives its reply from the output register;
// the next input is taken once that register has emptied.
// A tick rotates the row of slot cells once, one slot per cycle while the output
// is not stalled, through the update logic at the head, then gives the final
// result from the flush state. A stall on the output holds the rotation. Reset
// clears every slot's registered and active flags.
module periodic_task_tick_scheduler_unit import ptts_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int FIRE_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   walk_q, walk_d;
  logic [FIRE_W-1:0]  fire_cnt_q, fire_cnt_d;
  logic               pend_valid_q, pend_valid_d;
  logic [2:0]         pend_idx_q, pend_idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   in_range;
  logic                   sel_registered;
  logic [31:0]            delay_ext, period_ext, walk_ext;
  logic [COUNT_WIDTH-1:0] load_delay, load_period;
  logic                   shift;
  logic                   wr_task, wr_state;
  logic [2:0]             walk_idx;

  logic                   registered_w [TASK_SLOTS];
  logic                   active_w     [TASK_SLOTS];
  logic [COUNT_WIDTH-1:0] countdown_w  [TASK_SLOTS];
  logic [COUNT_WIDTH-1:0] period_w     [TASK_SLOTS];

  logic                   head_fire;
  logic [COUNT_WIDTH-1:0] head_countdown;

  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Trim or widen the loaded counts to the counter width
  assign delay_ext   = {16'b0, in_data_i.start_delay};
  assign period_ext  = {16'b0, in_data_i.period};
  assign load_delay  = delay_ext[COUNT_WIDTH-1:0];
  assign load_period = period_ext[COUNT_WIDTH-1:0];

  assign in_range       = {24'b0, in_data_i.slot} < 32'(TASK_SLOTS);
  assign sel_registered = in_range && registered_w[in_data_i.slot[IDX_W-1:0]];

  assign walk_ext = 32'(walk_q);
  assign walk_idx = walk_ext[2:0];

  // Slot update at the head of the row
  ptts_head #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_head (
    .registered_i (registered_w[0]),
    .active_i     (active_w[0]),
    .countdown_i  (countdown_w[0]),
    .period_i     (period_w[0]),
    .fire_o       (head_fire),
    .countdown_o  (head_countdown)
  );

  // Row of slot cells; the updated head re-enters at the tail
  for (genvar i = 0; i < TASK_SLOTS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    logic                   nb_registered;
    logic                   nb_active;
    logic [COUNT_WIDTH-1:0] nb_countdown;
    logic [COUNT_WIDTH-1:0] nb_period;

    assign ctrl.shift    = shift;
    assign ctrl.wr_task  = wr_task && (in_data_i.slot == SLOT_W'(i));
    assign ctrl.wr_state = wr_state && (in_data_i.slot == SLOT_W'(i));
    assign ctrl.active   = in_data_i.active;

    if (i == TASK_SLOTS - 1) begin : g_tail
      assign nb_registered = registered_w[0];
      assign nb_active     = active_w[0];
      assign nb_countdown  = head_countdown;
      assign nb_period     = period_w[0];
    end else begin : g_mid
      assign nb_registered = registered_w[i+1];
      assign nb_active     = active_w[i+1];
      assign nb_countdown  = countdown_w[i+1];
      assign nb_period     = period_w[i+1];
    end

    ptts_cell #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cell (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .ctrl_i          (ctrl),
      .load_delay_i    (load_delay),
      .load_period_i   (load_period),
      .nb_registered_i (nb_registered),
      .nb_active_i     (nb_active),
      .nb_countdown_i  (nb_countdown),
      .nb_period_i     (nb_period),
      .registered_o    (registered_w[i]),
      .active_o        (active_w[i]),
      .countdown_o     (countdown_w[i]),
      .period_o        (period_w[i])
    );
  end

  // Sequence transactions, the tick walk and the result register
  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    fire_cnt_d   = fire_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_idx_d   = pend_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    shift        = 1'b0;
    wr_task      = 1'b0;
    wr_state     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.action)
            ACT_TICK: begin
              state_d      = S_WALK;
              walk_d       = '0;
              fire_cnt_d   = '0;
              pend_valid_d = 1'b0;
            end
            ACT_REG: begin
              out_valid_d           = 1'b1;
              out_data_d.kind       = KIND_STATUS;
              out_data_d.task_index = 3'd0;
              out_data_d.last       = 1'b1;
              if (!in_range) begin
                out_data_d.status = STAT_BAD_PRIO;
              end else if (!in_data_i.task_present) begin
                out_data_d.status = STAT_NULL;
              end else begin
                out_data_d.status = STAT_OK;
                wr_task           = 1'b1;
              end
            end
            ACT_STATE: begin
              out_valid_d           = 1'b1;
              out_data_d.kind       = KIND_STATUS;
              out_data_d.task_index = 3'd0;
              out_data_d.last       = 1'b1;
              if (!in_range) begin
                out_data_d.status = STAT_BAD_PRIO;
              end else if (!sel_registered) begin
                out_data_d.status = STAT_UNREG;
              end else begin
                out_data_d.status = STAT_OK;
                wr_state          = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (out_free) begin
          shift = 1'b1;
          // Hold the newest fire back until the walk shows whether it is last
          if (head_fire && (fire_cnt_q < FIRE_W'(MAX_RESULTS))) begin
            if (pend_valid_q) begin
              out_valid_d           = 1'b1;
              out_data_d.kind       = KIND_FIRE;
              out_data_d.task_index = pend_idx_q;
              out_data_d.status     = STAT_OK;
              out_data_d.last       = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_idx_d   = walk_idx;
            fire_cnt_d   = fire_cnt_q + FIRE_W'(1);
          end
          if (walk_q == IDX_W'(TASK_SLOTS - 1)) begin
            state_d = S_FLUSH;
          end else begin
            walk_d = walk_q + IDX_W'(1);
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_data_d.status = STAT_OK;
          out_data_d.last   = 1'b1;
          if (pend_valid_q) begin
            out_data_d.kind       = KIND_FIRE;
            out_data_d.task_index = pend_idx_q;
          end else begin
            out_data_d.kind       = KIND_IDLE;
            out_data_d.task_index = 3'd0;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      walk_q       <= '0;
      fire_cnt_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      fire_cnt_q   <= fire_cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/ptts_cell.sv -----
module ptts_cell import ptts_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctrl_t             ctrl_i,
  input  logic [COUNT_WIDTH-1:0] load_delay_i,
  input  logic [COUNT_WIDTH-1:0] load_period_i,
  input  logic                   nb_registered_i,
  input  logic                   nb_active_i,
  input  logic [COUNT_WIDTH-1:0] nb_countdown_i,
  input  logic [COUNT_WIDTH-1:0] nb_period_i,
  output logic                   registered_o,
  output logic                   active_o,
  output logic [COUNT_WIDTH-1:0] countdown_o,
  output logic [COUNT_WIDTH-1:0] period_o
);

  logic                   registered_q, registered_d;
  logic                   active_q, active_d;
  logic [COUNT_WIDTH-1:0] countdown_q, countdown_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;

  // Take the neighbour's slot on a shift, else load or hold
  always_comb begin
    registered_d = registered_q;
    active_d     = active_q;
    countdown_d  = countdown_q;
    period_d     = period_q;
    if (ctrl_i.shift) begin
      registered_d = nb_registered_i;
      active_d     = nb_active_i;
      countdown_d  = nb_countdown_i;
      period_d     = nb_period_i;
    end else if (ctrl_i.wr_task) begin
      registered_d = 1'b1;
      active_d     = ctrl_i.active;
      countdown_d  = load_delay_i;
      period_d     = load_period_i;
    end else if (ctrl_i.wr_state) begin
      active_d = ctrl_i.active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      registered_q <= 1'b0;
      active_q     <= 1'b0;
    end else begin
      registered_q <= registered_d;
      active_q     <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    countdown_q <= countdown_d;
    period_q    <= period_d;
  end

  assign registered_o = registered_q;
  assign active_o     = active_q;
  assign countdown_o  = countdown_q;
  assign period_o     = period_q;

endmodule

// ----- rtl/ptts_head.sv -----
module ptts_head import ptts_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   registered_i,
  input  logic                   active_i,
  input  logic [COUNT_WIDTH-1:0] countdown_i,
  input  logic [COUNT_WIDTH-1:0] period_i,
  output logic                   fire_o,
  output logic [COUNT_WIDTH-1:0] countdown_o
);

  logic                   live;
  logic [COUNT_WIDTH-1:0] reload;

  // For a live slot fire on zero, reload from the period, then count down with wrap; else hold
  assign live        = registered_i && active_i;
  assign fire_o      = live && (countdown_i == '0);
  assign reload      = fire_o ? period_i : countdown_i;
  assign countdown_o = live ? (reload - COUNT_WIDTH'(1)) : countdown_i;

endmodule

// ----- dv/ptts_checker.sv -----
`timescale 1ns / 1ps

module ptts_checker import ptts_pkg::*; #(
  parameter int TASK_SLOTS  = TASK_SLOTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  output int        pending_o,
  output int        mismatch_count_o
);

  // Shadow copy of the slot table
  logic                   slot_known  [TASK_SLOTS];
  logic                   slot_live   [TASK_SLOTS];
  logic [COUNT_WIDTH-1:0] slot_count  [TASK_SLOTS];
  logic [COUNT_WIDTH-1:0] slot_reload [TASK_SLOTS];

  // Results still owed by the block, oldest first
  out_item_t due_results[$];
  int        mismatches = 0;

  initial pending_o = 0;
  assign mismatch_count_o = mismatches;

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_item_t want;
    out_item_t res;
    status_e   reply;
    int        fires;

    if (!rst_ni) begin
      for (int s = 0; s < TASK_SLOTS; s++) begin
        slot_known[s]  = 1'b0;
        slot_live[s]   = 1'b0;
        slot_count[s]  = '0;
        slot_reload[s] = '0;
      end
      due_results.delete();
      pending_o <= 0;
    end else begin
      // Compare each result transaction with the oldest one owed
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d task_index %0d status %0d last %0d",
                 out_data_i.kind, out_data_i.task_index, out_data_i.status,
                 out_data_i.last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_data_i.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_data_i.kind);
            mismatches++;
          end
          if (out_data_i.task_index !== want.task_index) begin
            $error("task_index: expected %0d, actual %0d", want.task_index,
                   out_data_i.task_index);
            mismatches++;
          end
          if (out_data_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status,
                   out_data_i.status);
            mismatches++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data_i.last);
            mismatches++;
          end
        end
      end

      // Advance the shadow table on each input transaction
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.action)
          ACT_TICK: begin
            fires = 0;
            // Walk slots upward: fire and reload at zero, then count down
            for (int s = 0; s < TASK_SLOTS; s++) begin
              if (slot_known[s] && slot_live[s]) begin
                if (slot_count[s] == '0) begin
                  if (fires < MAX_RESULTS) begin
                    res = '{KIND_FIRE, 3'(s), STAT_OK, 1'b0};
                    due_results.push_back(res);
                    fires++;
                  end
                  slot_count[s] = slot_reload[s];
                end
                slot_count[s] = slot_count[s] - 1'b1;
              end
            end
            if (fires == 0) begin
              res = '{KIND_IDLE, 3'd0, STAT_OK, 1'b1};
              due_results.push_back(res);
            end else begin
              due_results[due_results.size() - 1].last = 1'b1;
            end
          end
          ACT_REG: begin
            // Range is checked before the null task
            if (in_data_i.slot >= TASK_SLOTS) begin
              reply = STAT_BAD_PRIO;
            end else if (!in_data_i.task_present) begin
              reply = STAT_NULL;
            end else begin
              reply = STAT_OK;
              slot_known[in_data_i.slot]  = 1'b1;
              slot_live[in_data_i.slot]   = in_data_i.active;
              slot_count[in_data_i.slot]  = COUNT_WIDTH'(in_data_i.start_delay);
              slot_reload[in_data_i.slot] = COUNT_WIDTH'(in_data_i.period);
            end
            res = '{KIND_STATUS, 3'd0, reply, 1'b1};
            due_results.push_back(res);
          end
          ACT_STATE: begin
            if (in_data_i.slot >= TASK_SLOTS) begin
              reply = STAT_BAD_PRIO;
            end else if (!slot_known[in_data_i.slot]) begin
              reply = STAT_UNREG;
            end else begin
              reply = STAT_OK;
              slot_live[in_data_i.slot] = in_data_i.active;
            end
            res = '{KIND_STATUS, 3'd0, reply, 1'b1};
            due_results.push_back(res);
          end
          default: begin
            // Unused action: no change, no result
          end
        endcase
      end

      pending_o <= due_results.size();
    end
  end

endmodule

// ----- dv/tb_periodic_task_tick_scheduler_unit.sv -----
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler_unit;
  import ptts_pkg::*;

  localparam int TASK_SLOTS     = TASK_SLOTS_DEF;
  localparam int COUNT_WIDTH    = COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 385;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_pattern_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        pending;
  int        mismatches;

  int             burst_left    = 0;
  int             pattern_left  = 0;
  stall_pattern_e stall_pattern = STALL_NONE;

  periodic_task_tick_scheduler_unit #(
    .TASK_SLOTS  (TASK_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ptts_checker #(
    .TASK_SLOTS  (TASK_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .pending_o        (pending),
    .mismatch_count_o (mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result channel, switching pattern every so often
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left  = $urandom_range(16, 160);
      stall_pattern = stall_pattern_e'($urandom_range(0, 3));
    end
    pattern_left--;
    case (stall_pattern)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      default:     out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic in_item_t make_request(action_e act, int unsigned slot,
                                            bit present, int unsigned delay,
                                            int unsigned per, bit live);
    in_item_t item;
    item.action       = act;
    item.slot         = SLOT_W'(slot);
    item.task_present = present;
    item.start_delay  = 16'(delay);
    item.period       = 16'(per);
    item.active       = live;
    return item;
  endfunction

  // Mostly a valid slot, sometimes anywhere in the field
  function automatic int unsigned pick_slot();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                       : $urandom_range(0, TASK_SLOTS - 1);
  endfunction

  // Mostly short countdowns so that slots fire often
  function automatic int unsigned pick_count();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                       : $urandom_range(0, 5);
  endfunction

  // Offer one transaction; open a new burst after a random gap when due
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin : stimulus
    in_item_t item;
    int       counted;
    int       pick;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, unregistered slot, bad slots, null task, unused action
    send_item(make_request(ACT_TICK, 0, 1'b0, 0, 0, 1'b0));
    send_item(make_request(ACT_STATE, 3, 1'b1, 0, 0, 1'b1));
    send_item(make_request(ACT_REG, TASK_SLOTS, 1'b1, 4, 4, 1'b1));
    send_item(make_request(ACT_REG, 255, 1'b0, 65535, 65535, 1'b1));
    send_item(make_request(ACT_REG, 2, 1'b0, 1, 1, 1'b1));
    send_item(make_request(ACT_STATE, 200, 1'b1, 0, 0, 1'b0));
    send_item(make_request(ACT_NONE, 1, 1'b1, 0, 0, 1'b1));

    // Fill every slot so that the first tick fires all of them
    send_item(make_request(ACT_REG, 0, 1'b1, 0, 0, 1'b1));
    for (int s = 1; s < TASK_SLOTS - 1; s++) begin
      send_item(make_request(ACT_REG, s, 1'b1, 0, 2, 1'b1));
    end
    send_item(make_request(ACT_REG, TASK_SLOTS - 1, 1'b1, 0, 65535, 1'b1));
    repeat (3) send_item(make_request(ACT_TICK, 0, 1'b0, 0, 0, 1'b0));

    // Suspend, re-register with the largest delay and a zero period, resume
    send_item(make_request(ACT_STATE, 0, 1'b1, 0, 0, 1'b0));
    send_item(make_request(ACT_STATE, 9, 1'b1, 0, 0, 1'b1));
    send_item(make_request(ACT_REG, TASK_SLOTS - 2, 1'b1, 65535, 0, 1'b0));
    send_item(make_request(ACT_STATE, TASK_SLOTS - 2, 1'b0, 0, 0, 1'b1));
    repeat (2) send_item(make_request(ACT_TICK, 255, 1'b1, 65535, 65535, 1'b1));

    // Random mix, weighted towards ticks and registrations
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        item = make_request(ACT_TICK, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
      end else if (pick < 75) begin
        item = make_request(ACT_REG, pick_slot(), $urandom_range(0, 9) != 0,
                            pick_count(), pick_count(), $urandom_range(0, 4) != 0);
      end else if (pick < 95) begin
        item = make_request(ACT_STATE, pick_slot(), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 2) != 0);
      end else begin
        item = make_request(ACT_NONE, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
      end
      if (item.action != ACT_NONE) begin
        counted++;
      end
      send_item(item);
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain owed results, then let a full rotation pass
    while (pending != 0) @(posedge clk);
    repeat (4 * TASK_SLOTS) @(posedge clk);

    if (mismatches == 0) begin
      $display("periodic_task_tick_scheduler_unit: match");
    end else begin
      $display("periodic_task_tick_scheduler_unit: mismatch");
    end
    $finish;
  end

  // End the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("periodic_task_tick_scheduler_unit: mismatch");
    $finish;
  end

endmodule

// ----- periodic_task_tick_scheduler_unit.f -----
rtl/ptts_pkg.sv
rtl/ptts_cell.sv
rtl/ptts_head.sv
rtl/periodic_task_tick_scheduler_unit.sv
dv/ptts_checker.sv
dv/tb_periodic_task_tick_scheduler_unit.sv
